// ===== sv/ptwt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the pressure trend window tracker.
// No dependencies; imported by ptwt_div, pressure_trend_window_tracker and tb_top.
package ptwt_pkg;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned PRES_W   = 18;
  localparam int unsigned IVL_W    = 27;
  localparam int unsigned MINS_W   = 5;
  localparam int unsigned TREND_W  = 22;
  localparam int unsigned WMIN_W   = 17;
  localparam int unsigned CFG_AW   = 2;

  // Divider geometry: dividend is |dp| * 3 h in ms (18 x 24 bits).
  localparam int unsigned DVD_W    = 42;
  localparam int unsigned DVS_W    = 32;

  localparam logic [23:0]        MS_THREE_HOURS = 24'd10800000;
  localparam logic [DVS_W-1:0]   MS_PER_MINUTE  = 32'd60000;
  localparam logic [DVD_W-1:0]   TREND_LIMIT    = 42'd1572858;

  // Minutes by reciprocal: 60000 = 32 * 1875, and for n < 2^27
  // floor(n / 1875) = (n * MIN_RECIP) >> MIN_SHIFT
  localparam int unsigned MIN_PRE_SH  = 5;
  localparam int unsigned MIN_RECIP_W = 28;
  localparam int unsigned MIN_SHIFT   = 38;
  localparam int unsigned MIN_PROD_W  = TIME_W - MIN_PRE_SH + MIN_RECIP_W;
  localparam logic [MIN_RECIP_W-1:0] MIN_RECIP = 28'd146601551;

  localparam logic [IVL_W-1:0]   RST_SAMPLE_INTERVAL = 27'd600000;
  localparam logic [IVL_W-1:0]   RST_MIN_WINDOW      = 27'd1800000;
  localparam logic [MINS_W-1:0]  RST_MIN_SAMPLES     = 5'd4;

  // Register indexes on the configuration port
  localparam logic [CFG_AW-1:0]  REG_SAMPLE_INTERVAL = 2'd0;
  localparam logic [CFG_AW-1:0]  REG_MIN_WINDOW      = 2'd1;
  localparam logic [CFG_AW-1:0]  REG_MIN_SAMPLES     = 2'd2;

  // One ring entry
  typedef struct packed {
    logic [TIME_W-1:0] t_ms;
    logic [PRES_W-1:0] pres;
    logic              ok;
  } entry_t;

  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [DVS_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DVD_W-1:0]  quotient;
  } div_rsp_t;

endpackage

// ===== sv/ptwt_div.sv =====
`timescale 1ns / 1ps
// Serial restoring divider, two quotient bits per cycle.
// Depends on ptwt_pkg for widths and the request/response structs.
module ptwt_div
  import ptwt_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned STEPS = DVD_W / 2;
  localparam int unsigned CNT_W = $clog2(STEPS + 1);

  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [DVS_W-1:0] dvs_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;

  logic [DVS_W:0]   sh_a, sh_b;
  logic [DVS_W-1:0] rem_a;
  logic [DVD_W-1:0] dvd_a;
  logic             qa, qb;

  // two dependent restoring steps
  always_comb begin
    sh_a  = {rem_q, dvd_q[DVD_W-1]};
    qa    = (sh_a >= {1'b0, dvs_q});
    rem_a = qa ? DVS_W'(sh_a - {1'b0, dvs_q}) : sh_a[DVS_W-1:0];
    dvd_a = {dvd_q[DVD_W-2:0], qa};
    sh_b  = {rem_a, dvd_a[DVD_W-1]};
    qb    = (sh_b >= {1'b0, dvs_q});
    rem_d = qb ? DVS_W'(sh_b - {1'b0, dvs_q}) : sh_b[DVS_W-1:0];
    dvd_d = {dvd_a[DVD_W-2:0], qb};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(STEPS);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      dvd_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dvd_q <= dvd_d;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dvd_q;

endmodule

// ===== sv/pressure_trend_window_tracker.sv =====
`timescale 1ns / 1ps
// Top level of the three-hour pressure tendency tracker: ring memory, sequencer, output register.
// Depends on ptwt_pkg and ptwt_div.

// Takes timestamped pressure readings (0.01 hPa) one item at a time. The first reading after
// reset is always taken; after that a reading is taken only once sample_interval_ms has passed
// since the last taken one (32-bit wrap-safe time). A rejected reading gives no result and the
// block is ready again in the next cycle. A taken reading is written into a ring of RING_DEPTH
// entries and produces exactly one result item comparing it with the oldest stored entry: the
// change scaled to three hours (truncated toward zero, saturating at +/-1572858) and the span in
// whole minutes, or tendency_valid_o low with zero fields when there are too few samples, the
// span is zero or shorter than min_window_ms, or either end is flagged not ok. A reading that
// yields a valid trend holds in_ready_o low through the write, read, check, divide-start,
// divide and finish steps, with one pass through the 2-bit-per-cycle divider; the minutes come
// from a reciprocal multiply alongside. An invalid trend holds in_ready_o low through write,
// read, check and finish steps. The result sits in an output register, so the next reading is
// taken while a result still waits for out_ready_i; a second result stalls in the finish step
// until that register frees. Configuration is a plain write port and is to be written only
// while the block is idle. The ring needs no clearing after reset: only entries written since
// reset are ever read.
module pressure_trend_window_tracker
  import ptwt_pkg::*;
#(
  parameter int unsigned RING_DEPTH = 20
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration
  input  logic                      cfg_we_i,
  input  logic [CFG_AW-1:0]         cfg_addr_i,
  input  logic [IVL_W-1:0]          cfg_wdata_i,
  // input items
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [TIME_W-1:0]         sample_time_ms_i,
  input  logic [PRES_W-1:0]         pressure_centi_hpa_i,
  input  logic                      pressure_ok_i,
  // result items
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      tendency_valid_o,
  output logic signed [TREND_W-1:0] trend_centi_hpa_3h_o,
  output logic [WMIN_W-1:0]         window_minutes_o
);

  localparam int unsigned IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned FW = $clog2(RING_DEPTH + 1);
  localparam int unsigned CW = (FW > MINS_W) ? FW : MINS_W;

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_WRITE   = 7'b0000010,
    ST_READ    = 7'b0000100,
    ST_CHECK   = 7'b0001000,
    ST_DIVT_GO = 7'b0010000,
    ST_DIVT    = 7'b0100000,
    ST_FINISH  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [IVL_W-1:0]  interval_q, min_window_q;
  logic [MINS_W-1:0] min_samples_q;

  // ring control
  logic [IW-1:0]     head_q;
  logic [FW-1:0]     fill_q;
  logic [TIME_W-1:0] last_accept_q;
  logic              started_q;

  // ring storage, no reset
  entry_t            ring_mem [RING_DEPTH];
  entry_t            cur_q, old_q;
  logic [IW-1:0]     old_idx;
  logic [FW-1:0]     head_ext;

  // working values
  logic [TIME_W-1:0] window, window_q;
  logic [DVD_W-1:0]  prod_q;
  logic              neg_q;
  logic [PRES_W-1:0] mag;
  logic              trend_ok;
  logic [MIN_PROD_W-1:0] mins_prod;

  // result held until the output register is free
  logic                      res_valid_q;
  logic [TREND_W-1:0]        res_trend_q;
  logic [WMIN_W-1:0]         res_mins_q;
  logic [TREND_W-1:0]        trend_mag;

  logic                      out_valid_q, out_tv_q;
  logic [TREND_W-1:0]        out_trend_q;
  logic [WMIN_W-1:0]         out_mins_q;

  logic     in_acc, take, out_free;
  div_req_t div_req;
  div_rsp_t div_rsp;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign take       = !started_q ||
                      ((sample_time_ms_i - last_accept_q) >= TIME_W'(interval_q));
  assign out_free   = !out_valid_q || out_ready_i;

  // oldest entry after this write: (head - fill) mod depth
  assign head_ext = FW'(head_q);
  assign old_idx  = (head_ext >= fill_q) ? IW'(head_ext - fill_q)
                                         : IW'(head_ext + FW'(RING_DEPTH) - fill_q);

  // trend checks, newest entry is the current reading
  assign window   = cur_q.t_ms - old_q.t_ms;
  assign trend_ok = (CW'(fill_q) >= CW'(min_samples_q)) &&
                    (window != '0) && (window >= TIME_W'(min_window_q)) &&
                    old_q.ok && cur_q.ok;
  assign mag      = (cur_q.pres < old_q.pres) ? (old_q.pres - cur_q.pres)
                                              : (cur_q.pres - old_q.pres);

  // span in minutes: drop the factor 32 of 60000, then multiply by the reciprocal of 1875
  assign mins_prod = MIN_PROD_W'(window_q[TIME_W-1:MIN_PRE_SH]) * MIN_PROD_W'(MIN_RECIP);

  // saturate the quotient
  assign trend_mag = (div_rsp.quotient > TREND_LIMIT) ? TREND_W'(TREND_LIMIT)
                                                      : TREND_W'(div_rsp.quotient);

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = prod_q;
    div_req.divisor  = window_q;
    case (state_q)
      ST_DIVT_GO: div_req.start = 1'b1;
      default:    div_req.start = 1'b0;
    endcase
  end

  ptwt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (in_acc && take) state_d = ST_WRITE;
      ST_WRITE:   state_d = ST_READ;
      ST_READ:    state_d = ST_CHECK;
      ST_CHECK:   state_d = trend_ok ? ST_DIVT_GO : ST_FINISH;
      ST_DIVT_GO: state_d = ST_DIVT;
      ST_DIVT:    if (div_rsp.done) state_d = ST_FINISH;
      ST_FINISH:  if (out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q    <= RST_SAMPLE_INTERVAL;
      min_window_q  <= RST_MIN_WINDOW;
      min_samples_q <= RST_MIN_SAMPLES;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_SAMPLE_INTERVAL: interval_q    <= cfg_wdata_i;
        REG_MIN_WINDOW:      min_window_q  <= cfg_wdata_i;
        REG_MIN_SAMPLES:     min_samples_q <= cfg_wdata_i[MINS_W-1:0];
        default:             ;
      endcase
    end
  end

  // acceptance gate and ring pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q     <= 1'b0;
      last_accept_q <= '0;
      head_q        <= '0;
      fill_q        <= '0;
    end else begin
      if (in_acc && take) begin
        started_q     <= 1'b1;
        last_accept_q <= sample_time_ms_i;
      end
      if (state_q == ST_WRITE) begin
        head_q <= (head_q == IW'(RING_DEPTH - 1)) ? '0 : head_q + 1'b1;
        if (fill_q != FW'(RING_DEPTH)) fill_q <= fill_q + 1'b1;
      end
    end
  end

  // ring memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cur_q <= '{t_ms: sample_time_ms_i, pres: pressure_centi_hpa_i, ok: pressure_ok_i};
    end
    if (state_q == ST_WRITE) ring_mem[head_q] <= cur_q;
    if (state_q == ST_READ)  old_q <= ring_mem[old_idx];
  end

  // working registers and result
  always_ff @(posedge clk_i) begin
    if (state_q == ST_CHECK) begin
      window_q    <= window;
      neg_q       <= (cur_q.pres < old_q.pres);
      prod_q      <= DVD_W'(mag) * DVD_W'(MS_THREE_HOURS);
      res_valid_q <= trend_ok;
      res_trend_q <= '0;
      res_mins_q  <= '0;
    end
    if (state_q == ST_DIVT_GO) begin
      res_mins_q <= mins_prod[MIN_SHIFT +: WMIN_W];
    end
    if (state_q == ST_DIVT && div_rsp.done) begin
      res_trend_q <= neg_q ? TREND_W'(-trend_mag) : trend_mag;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_FINISH && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FINISH && out_free) begin
      out_tv_q    <= res_valid_q;
      out_trend_q <= res_trend_q;
      out_mins_q  <= res_mins_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign tendency_valid_o     = out_tv_q;
  assign trend_centi_hpa_3h_o = signed'(out_trend_q);
  assign window_minutes_o     = out_mins_q;

  // checks
  a_ring_bounds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q < IW'(RING_DEPTH)) && (fill_q <= FW'(RING_DEPTH)))
    else $error("ring pointer out of range");

  a_invalid_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !tendency_valid_o) |-> (out_trend_q == '0) && (window_minutes_o == '0))
    else $error("invalid trend carries nonzero fields");

  a_trend_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && tendency_valid_o) |->
      (trend_centi_hpa_3h_o <= signed'(TREND_W'(TREND_LIMIT))) &&
      (trend_centi_hpa_3h_o >= -signed'(TREND_W'(TREND_LIMIT))))
    else $error("trend beyond saturation limit");

  a_div_done_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DIVT))
    else $error("divider finished outside the divide state");

  a_reject_stays_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !take) |=> (state_q == ST_IDLE) && $stable(head_q) && $stable(fill_q))
    else $error("rejected reading changed the ring");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for pressure_trend_window_tracker: directed and random readings,
// with a scoreboard class that predicts each trend result. Depends on ptwt_pkg and the RTL.
module tb_top;
  import ptwt_pkg::*;

  localparam int unsigned RING_DEPTH = 20;
  // Worst case per item is one divider pass plus sequencing
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned REPORT_LIMIT = 10;

  // One expected result item
  typedef struct {
    logic                      tv;
    logic signed [TREND_W-1:0] trend;
    logic [WMIN_W-1:0]         wmin;
  } tendency_t;

  // Mirror of the tracker state plus the queue of trend results still owed by the block
  class tendency_scoreboard;
    logic [TIME_W-1:0] times [RING_DEPTH];
    logic [PRES_W-1:0] pres  [RING_DEPTH];
    logic              oks   [RING_DEPTH];
    int unsigned       head;
    int unsigned       fill;
    logic [TIME_W-1:0] last_accept;
    logic              started;
    logic [IVL_W-1:0]  interval_ms;
    logic [IVL_W-1:0]  min_window_ms;
    logic [MINS_W-1:0] min_samples;
    tendency_t         owed_trends[$];
    int unsigned       mismatches;

    function new();
      head          = 0;
      fill          = 0;
      last_accept   = '0;
      started       = 1'b0;
      interval_ms   = RST_SAMPLE_INTERVAL;
      min_window_ms = RST_MIN_WINDOW;
      min_samples   = RST_MIN_SAMPLES;
      mismatches    = 0;
    endfunction

    function void set_reg(logic [CFG_AW-1:0] idx, logic [IVL_W-1:0] val);
      case (idx)
        REG_SAMPLE_INTERVAL: interval_ms   = val;
        REG_MIN_WINDOW:      min_window_ms = val;
        REG_MIN_SAMPLES:     min_samples   = val[MINS_W-1:0];
        default: ;
      endcase
    endfunction

    // Accepted input: decide whether the reading is taken and, if so, what it yields
    function void note_reading(logic [TIME_W-1:0] now, logic [PRES_W-1:0] p, logic ok);
      logic [TIME_W-1:0] gap;
      logic [TIME_W-1:0] span;
      int unsigned       newest;
      int unsigned       oldest;
      longint            diff;
      longint unsigned   mag;
      longint unsigned   q;
      tendency_t         e;
      gap = now - last_accept;
      if (started && gap < {5'd0, interval_ms}) return;
      started         = 1'b1;
      last_accept     = now;
      times[head]     = now;
      pres[head]      = p;
      oks[head]       = ok;
      head            = (head + 1) % RING_DEPTH;
      if (fill < RING_DEPTH) fill++;
      e.tv    = 1'b0;
      e.trend = '0;
      e.wmin  = '0;
      if (fill >= min_samples) begin
        newest = (head + RING_DEPTH - 1) % RING_DEPTH;
        oldest = (head + RING_DEPTH - fill) % RING_DEPTH;
        span   = times[newest] - times[oldest];
        if (span != 0 && span >= {5'd0, min_window_ms} && oks[oldest] && oks[newest]) begin
          diff = longint'({46'd0, pres[newest]}) - longint'({46'd0, pres[oldest]});
          mag  = (diff < 0) ? longint'(-diff) : longint'(diff);
          q    = (mag * longint'(MS_THREE_HOURS)) / longint'(span);
          if (q > longint'(TREND_LIMIT)) q = longint'(TREND_LIMIT);
          e.tv    = 1'b1;
          e.trend = (diff < 0) ? -q[TREND_W-1:0] : q[TREND_W-1:0];
          e.wmin  = WMIN_W'(span / MS_PER_MINUTE);
        end
      end
      owed_trends.push_back(e);
    endfunction

    function void flag(string msg);
      if (mismatches < REPORT_LIMIT) $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
    endfunction

    // Accepted result: compare with the oldest owed trend
    function void check_tendency(logic tv, logic signed [TREND_W-1:0] trend,
                                 logic [WMIN_W-1:0] wmin);
      tendency_t e;
      if (owed_trends.size() == 0) begin
        flag($sformatf("result with nothing owed: valid=%0b trend=%0d min=%0d",
                       tv, trend, wmin));
        return;
      end
      e = owed_trends.pop_front();
      if (tv !== e.tv || trend !== e.trend || wmin !== e.wmin)
        flag($sformatf("exp valid=%0b trend=%0d min=%0d, got valid=%0b trend=%0d min=%0d",
                       e.tv, e.trend, e.wmin, tv, trend, wmin));
    endfunction
  endclass

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [CFG_AW-1:0]         cfg_addr_i;
  logic [IVL_W-1:0]          cfg_wdata_i;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic [TIME_W-1:0]         sample_time_ms_i;
  logic [PRES_W-1:0]         pressure_centi_hpa_i;
  logic                      pressure_ok_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic                      tendency_valid_o;
  logic signed [TREND_W-1:0] trend_centi_hpa_3h_o;
  logic [WMIN_W-1:0]         window_minutes_o;

  tendency_scoreboard sb = new();
  // High while neither side idles nor stalls
  logic steady;
  // Random walk for realistic pressure drift
  logic [PRES_W-1:0] walk;

  pressure_trend_window_tracker #(
    .RING_DEPTH(RING_DEPTH)
  ) dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_addr_i           (cfg_addr_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .sample_time_ms_i     (sample_time_ms_i),
    .pressure_centi_hpa_i (pressure_centi_hpa_i),
    .pressure_ok_i        (pressure_ok_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .tendency_valid_o     (tendency_valid_o),
    .trend_centi_hpa_3h_o (trend_centi_hpa_3h_o),
    .window_minutes_o     (window_minutes_o)
  );

  // 8 ns clock
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Result side: stall about 22 percent of the time, never while steady
  always @(negedge clk_i) begin
    out_ready_i = steady || ($urandom_range(99) >= 22);
  end

  // Results are sampled at the rising edge, on the handshake
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_tendency(tendency_valid_o, trend_centi_hpa_3h_o, window_minutes_o);
  end

  // Offer one reading; called at a falling edge, returns at a falling edge.
  // Valid stays high from one item to the next unless an idle cycle comes between.
  task automatic send_reading(logic [TIME_W-1:0] t, logic [PRES_W-1:0] p, logic ok);
    while (!steady && $urandom_range(99) < 22) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i           = 1'b1;
    sample_time_ms_i     = t;
    pressure_centi_hpa_i = p;
    pressure_ok_i        = ok;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_reading(t, p, ok);
    @(negedge clk_i);
  endtask

  // Let every owed result come out, then give a reading that yields nothing time to settle
  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (sb.owed_trends.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Write all three registers on consecutive cycles; block is idle here
  task automatic apply_settings(logic [IVL_W-1:0] ivl, logic [IVL_W-1:0] win,
                                logic [IVL_W-1:0] mins);
    logic [CFG_AW-1:0] idx [3];
    logic [IVL_W-1:0]  val [3];
    idx = '{REG_SAMPLE_INTERVAL, REG_MIN_WINDOW, REG_MIN_SAMPLES};
    val = '{ivl, win, mins};
    for (int i = 0; i < 3; i++) begin
      cfg_we_i    = 1'b1;
      cfg_addr_i  = idx[i];
      cfg_wdata_i = val[i];
      sb.set_reg(idx[i], val[i]);
      @(negedge clk_i);
    end
    cfg_we_i = 1'b0;
  endtask

  // Random readings: mostly spaced just past the interval so the ring fills and trends form,
  // some too soon (rejected unless the interval is zero), some with an arbitrary 32-bit jump
  task automatic random_readings(int unsigned n);
    logic [TIME_W-1:0] ivl;
    logic [TIME_W-1:0] t;
    int unsigned       r;
    for (int unsigned k = 0; k < n; k++) begin
      ivl = {5'd0, sb.interval_ms};
      r   = $urandom_range(99);
      if (r < 70)
        t = sb.last_accept + ivl + $urandom_range(ivl / 4 + 3);
      else if (r < 85)
        t = sb.last_accept + ((ivl == 0) ? 32'd0 : $urandom_range(ivl - 1));
      else
        t = $urandom;
      if ($urandom_range(1)) walk = PRES_W'(walk + $urandom_range(1000) - 500);
      else walk = PRES_W'($urandom);
      send_reading(t, walk, $urandom_range(99) < 90);
    end
  endtask

  localparam logic [TIME_W-1:0] T0 = 32'hFFF0_BDC0;  // one million ms before the wrap

  initial begin
    logic [IVL_W-1:0] ivl;
    rst_ni               = 1'b0;
    steady               = 1'b0;
    walk                 = 18'd101325;
    cfg_we_i             = 1'b0;
    cfg_addr_i           = REG_SAMPLE_INTERVAL;
    cfg_wdata_i          = '0;
    in_valid_i           = 1'b0;
    sample_time_ms_i     = '0;
    pressure_centi_hpa_i = '0;
    pressure_ok_i        = 1'b0;
    out_ready_i          = 1'b1;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed, reset settings. First reading always taken, too-soon reading dropped,
    // time crosses the 32-bit wrap, too few samples, pressure extremes, newest not ok,
    // window exactly at the minimum, negative trend truncated toward zero.
    send_reading(T0,                 18'd131072, 1'b1);
    send_reading(T0 + 32'd100,       18'd7,      1'b1);
    send_reading(T0 + 32'd600000,    18'd262143, 1'b1);
    send_reading(T0 + 32'd1200000,   18'd5,      1'b0);
    send_reading(T0 + 32'd1800000,   18'd262143, 1'b1);
    send_reading(T0 + 32'd2400000,   18'd0,      1'b0);
    send_reading(T0 + 32'd2999999,   18'd9,      1'b1);
    send_reading(T0 + 32'd3000000,   18'd0,      1'b1);
    wait_idle();

    // Zero interval takes everything; zero span is invalid; one-ms span saturates both ways
    apply_settings(27'd0, 27'd0, 27'd2);
    send_reading(T0,         18'd42,     1'b1);
    send_reading(T0 + 32'd1, 18'd262143, 1'b1);
    send_reading(T0 + 32'd1, 18'd0,      1'b1);
    send_reading(T0 + 32'd1, 18'd131072, 1'b1);
    wait_idle();

    // Largest register values; minimum sample count above the ring depth never gives a trend
    apply_settings(27'h7FF_FFFF, 27'h7FF_FFFF, 27'd31);
    send_reading(T0 + 32'd2,                18'd1,      1'b1);
    send_reading(T0 + 32'd2 + 32'h7FF_FFFF, 18'd262143, 1'b1);
    send_reading(32'hFFFF_FFFF,             18'd0,      1'b0);
    wait_idle();

    // Random phases, each under its own settings; the ring carries over between phases
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: apply_settings(RST_SAMPLE_INTERVAL, RST_MIN_WINDOW, {22'd0, RST_MIN_SAMPLES});
        1: apply_settings(27'd1, 27'd0, 27'd2);
        2: apply_settings(27'd86400000, 27'd86400000, 27'd20);
        3: apply_settings(27'h7FF_FFFF, 27'h7FF_FFFF, 27'd2);
        4: apply_settings(27'd0, 27'd1000, 27'd3);
        8: apply_settings(27'd600000, 27'd0, 27'd31);
        default: begin
          ivl = IVL_W'($urandom_range(2000000, 1));
          apply_settings(ivl, IVL_W'($urandom_range(ivl * 20)),
                         IVL_W'($urandom_range(20, 2)));
        end
      endcase
      steady = (ph == 2);  // one long stretch with no idling on either side
      random_readings((ph == 8) ? 40 : ((ph == 3) ? 120 : 150));
      steady = 1'b0;
      wait_idle();
    end

    if (sb.mismatches == 0 && sb.owed_trends.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
